/* hw/rtl/indexed_min_heap_decrease_key_top_defines.svh */
// assertion macros for the indexed min-heap block
// no dependencies
`ifndef INDEXED_MIN_HEAP_DECREASE_KEY_TOP_DEFINES_SVH
`define INDEXED_MIN_HEAP_DECREASE_KEY_TOP_DEFINES_SVH

// assert that a condition implies a consequence on the same edge
`define IMH_ASSERT_IMPL(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");

// assert that a condition implies a consequence on the next edge
`define IMH_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hw/rtl/imh_pkg.sv */
// shared types and constants for the indexed min-heap
// no dependencies
package imh_pkg;
   localparam int CAPACITY = 1024;
   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int HANDLE_W = 10;
   localparam int HANDLES = 1 << HANDLE_W;
   localparam int KEY_W = 64;
   localparam int DEC_W = 31;

   localparam logic [1:0] OP_QUERY = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_EXTRACT = 2'd2;
   localparam logic [1:0] OP_DECREASE = 2'd3;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_EMPTY = 3'd1;
   localparam logic [2:0] ST_FULL = 3'd2;
   localparam logic [2:0] ST_ABSENT = 3'd3;
   localparam logic [2:0] ST_DUP = 3'd4;

   // datapath command codes
   localparam logic [3:0] CMD_NONE = 4'd0;
   localparam logic [3:0] CMD_CLEAR = 4'd1;
   localparam logic [3:0] CMD_LATCH = 4'd2;
   localparam logic [3:0] CMD_RD_POS = 4'd3;
   localparam logic [3:0] CMD_RD_A = 4'd4;
   localparam logic [3:0] CMD_RD_B = 4'd5;
   localparam logic [3:0] CMD_WR_NEW = 4'd6;
   localparam logic [3:0] CMD_WR_DEC = 4'd7;
   localparam logic [3:0] CMD_WR_SWAP = 4'd8;
   localparam logic [3:0] CMD_WR_LAST = 4'd9;
   localparam logic [3:0] CMD_RD_C = 4'd10;
   localparam logic [3:0] CMD_RD_MIN = 4'd11;
   localparam logic [3:0] CMD_WR_SWAP2 = 4'd12;
   localparam logic [3:0] CMD_FIN = 4'd13;
   localparam logic [3:0] CMD_RD_LAST = 4'd14;

   typedef struct packed {
      logic [3:0] cmd;
   } imh_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic present;
      logic full;
      logic empty;
      logic at_root;
      logic up_less;
      logic has_left;
      logic down_swap;
      logic pos_valid;
   } imh_status_type;
endpackage

/* hw/rtl/imh_datapath.sv */
// heap memories, position table, comparators and counters
// depends on imh_pkg
module imh_datapath
   import imh_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  imh_cmd_type          cmd,
   input  logic [1:0]           req_operation,
   input  logic [HANDLE_W-1:0]  req_handle,
   input  logic [KEY_W-1:0]     req_key_value,
   input  logic [DEC_W-1:0]     req_decrement,
   output imh_status_type       stat,
   output logic [KEY_W-1:0]     min_key,
   output logic [HANDLE_W-1:0]  min_handle,
   output logic [CNT_W-1:0]     count
);
   logic [KEY_W-1:0] key_mem [CAPACITY];
   logic [HANDLE_W-1:0] hdl_mem [CAPACITY];
   logic [SLOT_W:0] pos_mem [HANDLES];  // msb is present bit

   logic [HANDLE_W-1:0] clr_ff, clr_in;
   logic clr_done_ff, clr_done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] res_cnt_ff, res_cnt_in;
   logic [1:0] op_ff;
   logic [HANDLE_W-1:0] h_ff;
   logic [KEY_W-1:0] key_ff;
   logic [DEC_W-1:0] dec_ff;
   logic [SLOT_W-1:0] cur_ff;     // slot being sifted
   logic [SLOT_W-1:0] oth_ff;     // old slot in sift up, or chosen child
   logic [KEY_W-1:0] ka_ff, kb_ff, kc_ff;
   logic [HANDLE_W-1:0] ha_ff, hb_ff, hc_ff;
   logic [SLOT_W:0] pos_rd_ff;
   logic [KEY_W-1:0] min_key_ff;
   logic [HANDLE_W-1:0] min_hdl_ff;
   logic [SLOT_W-1:0] rd_addr;
   logic [KEY_W-1:0] rd_key_ff;
   logic [HANDLE_W-1:0] rd_hdl_ff;
   logic [1:0] rd_tgt_ff;

   function automatic logic less(input logic [KEY_W-1:0] ka, input logic [HANDLE_W-1:0] ha,
                                 input logic [KEY_W-1:0] kb, input logic [HANDLE_W-1:0] hb);
      if (ka != kb) return $signed(ka) < $signed(kb);
      return ha < hb;
   endfunction

   logic [SLOT_W-1:0] parent;
   logic [CNT_W:0] left_c, right_c;
   logic right_ok, pick_right;
   logic [KEY_W-1:0] pk;
   logic [HANDLE_W-1:0] ph;

   assign parent = (cur_ff - SLOT_W'(1)) >> 1;
   assign left_c = (CNT_W+1)'({cur_ff, 1'b1});
   assign right_c = left_c + (CNT_W+1)'(1);
   assign right_ok = right_c < (CNT_W+1)'(cnt_ff);
   assign pick_right = right_ok && less(kc_ff, hc_ff, kb_ff, hb_ff);
   assign pk = pick_right ? kc_ff : kb_ff;
   assign ph = pick_right ? hc_ff : hb_ff;

   assign stat.clear_done = clr_done_ff;
   assign stat.present = pos_rd_ff[SLOT_W];
   assign stat.pos_valid = (CNT_W+1)'(pos_rd_ff[SLOT_W-1:0]) < (CNT_W+1)'(cnt_ff);
   assign stat.full = cnt_ff >= CNT_W'(CAPACITY);
   assign stat.empty = cnt_ff == '0;
   assign stat.at_root = cur_ff == '0;
   assign stat.up_less = less(ka_ff, ha_ff, kb_ff, hb_ff);
   assign stat.has_left = left_c < (CNT_W+1)'(cnt_ff);
   assign stat.down_swap = less(pk, ph, ka_ff, ha_ff);
   assign min_key = min_key_ff;
   assign min_handle = min_hdl_ff;
   assign count = res_cnt_ff;

   always_comb begin
      case (cmd.cmd)
         CMD_RD_A:    rd_addr = pos_rd_ff[SLOT_W-1:0];
         CMD_RD_B:    rd_addr = (op_ff == OP_EXTRACT) ? SLOT_W'(left_c) : parent;
         CMD_RD_C:    rd_addr = SLOT_W'(right_c);
         CMD_RD_LAST: rd_addr = SLOT_W'(cnt_ff - CNT_W'(1));
         default:     rd_addr = '0;
      endcase
   end

   always_comb begin
      clr_in = clr_ff;
      clr_done_in = clr_done_ff;
      if (cmd.cmd == CMD_CLEAR) begin
         clr_in = clr_ff + HANDLE_W'(1);
         if (clr_ff == HANDLE_W'(HANDLES - 1)) clr_done_in = 1'b1;
      end
      cnt_in = cnt_ff;
      if (cmd.cmd == CMD_WR_NEW) cnt_in = cnt_ff + CNT_W'(1);
      if (cmd.cmd == CMD_WR_LAST) cnt_in = cnt_ff - CNT_W'(1);
      res_cnt_in = res_cnt_ff;
      if (cmd.cmd == CMD_FIN) res_cnt_in = cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         clr_done_ff <= 1'b0;
         cnt_ff <= '0;
         res_cnt_ff <= '0;
      end else begin
         clr_ff <= clr_in;
         clr_done_ff <= clr_done_in;
         cnt_ff <= cnt_in;
         res_cnt_ff <= res_cnt_in;
      end
   end

   // memory read port, data registered
   always_ff @(posedge clock) begin
      rd_key_ff <= key_mem[rd_addr];
      rd_hdl_ff <= hdl_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      // route last cycle's read into its holding register
      case (rd_tgt_ff)
         2'd1: begin ka_ff <= rd_key_ff; ha_ff <= rd_hdl_ff; end
         2'd2: begin kb_ff <= rd_key_ff; hb_ff <= rd_hdl_ff; end
         2'd3: begin kc_ff <= rd_key_ff; hc_ff <= rd_hdl_ff; end
         default: ;
      endcase
      case (cmd.cmd)
         CMD_RD_A:    rd_tgt_ff <= 2'd1;
         CMD_RD_B:    rd_tgt_ff <= 2'd2;
         CMD_RD_C:    rd_tgt_ff <= 2'd3;
         CMD_RD_LAST: rd_tgt_ff <= 2'd1;
         default:     rd_tgt_ff <= 2'd0;
      endcase
      case (cmd.cmd)
         CMD_CLEAR: pos_mem[clr_ff] <= '0;
         CMD_LATCH: begin
            op_ff <= req_operation;
            h_ff <= req_handle;
            key_ff <= req_key_value;
            dec_ff <= req_decrement;
            cur_ff <= SLOT_W'(cnt_ff);
         end
         CMD_RD_POS: pos_rd_ff <= pos_mem[h_ff];
         CMD_WR_NEW: begin
            key_mem[SLOT_W'(cnt_ff)] <= key_ff;
            hdl_mem[SLOT_W'(cnt_ff)] <= h_ff;
            pos_mem[h_ff] <= {1'b1, SLOT_W'(cnt_ff)};
            ka_ff <= key_ff;
            ha_ff <= h_ff;
            cur_ff <= SLOT_W'(cnt_ff);
         end
         CMD_WR_DEC: begin
            cur_ff <= pos_rd_ff[SLOT_W-1:0];
            key_mem[pos_rd_ff[SLOT_W-1:0]] <= ka_ff - {{(KEY_W-DEC_W){1'b0}}, dec_ff};
            ka_ff <= ka_ff - {{(KEY_W-DEC_W){1'b0}}, dec_ff};
         end
         CMD_WR_SWAP: begin
            // sift up: a moves to parent, b moves to cur
            key_mem[parent] <= ka_ff; hdl_mem[parent] <= ha_ff;
            pos_mem[ha_ff] <= {1'b1, parent};
            oth_ff <= cur_ff;
            cur_ff <= parent;
         end
         CMD_WR_SWAP2: begin
            if (op_ff == OP_EXTRACT) begin
               key_mem[oth_ff] <= ka_ff; hdl_mem[oth_ff] <= ha_ff;
               pos_mem[ha_ff] <= {1'b1, oth_ff};
            end else begin
               key_mem[oth_ff] <= kb_ff; hdl_mem[oth_ff] <= hb_ff;
               pos_mem[hb_ff] <= {1'b1, oth_ff};
            end
         end
         CMD_WR_LAST: begin
            // move last entry to root, then drop root handle (it may be the same one)
            key_mem['0] <= ka_ff; hdl_mem['0] <= ha_ff;
            pos_mem[ha_ff] <= {1'b1, SLOT_W'(0)};
            pos_mem[min_hdl_ff] <= '0;
            cur_ff <= '0;
         end
         CMD_RD_MIN: begin
            // chosen child goes up to cur, a moves down
            oth_ff <= pick_right ? SLOT_W'(right_c) : SLOT_W'(left_c);
            key_mem[cur_ff] <= pk; hdl_mem[cur_ff] <= ph;
            pos_mem[ph] <= {1'b1, cur_ff};
            cur_ff <= pick_right ? SLOT_W'(right_c) : SLOT_W'(left_c);
         end
         CMD_FIN: begin
            min_key_ff <= cnt_ff == '0 ? '0 : rd_key_ff;
            min_hdl_ff <= cnt_ff == '0 ? '0 : rd_hdl_ff;
         end
         default: ;
      endcase
   end
endmodule

/* hw/rtl/imh_control.sv */
// sequencer for insert, extract and decrease-key sifting
// depends on imh_pkg
module imh_control
   import imh_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [1:0]      req_operation,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [2:0]      rsp_status,
   input  imh_status_type  stat,
   output imh_cmd_type     cmd
);
   localparam logic [4:0] S_CLEAR = 5'd0, S_IDLE = 5'd1, S_POS = 5'd2, S_POSW = 5'd3,
      S_DISP = 5'd4, S_DEC_RD = 5'd5, S_DEC_W1 = 5'd6, S_DEC_W2 = 5'd7, S_DEC_WR = 5'd8,
      S_UP = 5'd9, S_UP_W1 = 5'd10, S_UP_W2 = 5'd11, S_UP_CMP = 5'd12, S_UP_SW2 = 5'd13,
      S_EX_RD = 5'd14, S_EX_W1 = 5'd15, S_EX_W2 = 5'd16, S_DN = 5'd17, S_DN_B = 5'd18,
      S_DN_C = 5'd19, S_DN_W1 = 5'd20, S_DN_W2 = 5'd21, S_DN_SW2 = 5'd22,
      S_MIN = 5'd23, S_MIN_W1 = 5'd24, S_MIN_W2 = 5'd25, S_DONE = 5'd26;

   logic [4:0] state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic [2:0] st_ff, st_in;
   logic [2:0] rsp_st_ff, rsp_st_in;
   logic valid_ff, valid_in;

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = valid_ff;
   assign rsp_status = rsp_st_ff;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      st_in = st_ff;
      rsp_st_in = rsp_st_ff;
      valid_in = valid_ff && rsp_stall;
      cmd.cmd = CMD_NONE;
      case (state_ff)
         S_CLEAR: begin
            cmd.cmd = CMD_CLEAR;
            if (stat.clear_done) begin cmd.cmd = CMD_NONE; state_in = S_IDLE; end
         end
         S_IDLE: if (req_valid) begin
            cmd.cmd = CMD_LATCH; op_in = req_operation; st_in = ST_OK; state_in = S_POS;
         end
         S_POS: begin cmd.cmd = CMD_RD_POS; state_in = S_POSW; end
         S_POSW: state_in = S_DISP;
         S_DISP: begin
            state_in = S_MIN;
            case (op_ff)
               OP_INSERT:
                  if (stat.full) st_in = ST_FULL;
                  else if (stat.present) st_in = ST_DUP;
                  else begin cmd.cmd = CMD_WR_NEW; state_in = S_UP; end
               OP_EXTRACT:
                  if (stat.empty) st_in = ST_EMPTY;
                  else state_in = S_EX_RD;
               OP_DECREASE:
                  if (!stat.present) st_in = ST_ABSENT;
                  else if (stat.pos_valid) state_in = S_DEC_RD;
               default: ;
            endcase
         end
         S_DEC_RD: begin cmd.cmd = CMD_RD_A; state_in = S_DEC_W1; end
         S_DEC_W1: begin cmd.cmd = CMD_NONE; state_in = S_DEC_WR; end
         S_DEC_WR: state_in = S_DEC_W2;
         S_DEC_W2: begin cmd.cmd = CMD_WR_DEC; state_in = S_UP; end
         S_UP: begin
            if (stat.at_root) state_in = S_MIN;
            else begin cmd.cmd = CMD_RD_B; state_in = S_UP_W1; end
         end
         S_UP_W1: state_in = S_UP_W2;
         S_UP_W2: state_in = S_UP_CMP;
         S_UP_CMP: begin
            if (stat.up_less) begin cmd.cmd = CMD_WR_SWAP; state_in = S_UP_SW2; end
            else state_in = S_MIN;
         end
         S_UP_SW2: begin cmd.cmd = CMD_WR_SWAP2; state_in = S_UP; end
         S_EX_RD: begin cmd.cmd = CMD_RD_LAST; state_in = S_EX_W1; end
         S_EX_W1: state_in = S_EX_W2;
         S_EX_W2: state_in = S_DN;
         S_DN: begin cmd.cmd = CMD_WR_LAST; state_in = S_DN_B; end
         S_DN_B: begin
            if (!stat.has_left) state_in = S_MIN;
            else begin cmd.cmd = CMD_RD_B; state_in = S_DN_C; end
         end
         S_DN_C: begin cmd.cmd = CMD_RD_C; state_in = S_DN_W1; end
         S_DN_W1: state_in = S_DN_W2;
         S_DN_W2: begin
            if (stat.down_swap) begin cmd.cmd = CMD_RD_MIN; state_in = S_DN_SW2; end
            else state_in = S_MIN;
         end
         S_DN_SW2: begin cmd.cmd = CMD_WR_SWAP2; state_in = S_DN_B; end
         S_MIN: state_in = S_MIN_W1;
         S_MIN_W1: state_in = S_MIN_W2;
         S_MIN_W2: state_in = S_DONE;
         // result registers load only once the previous result has gone
         S_DONE: if (!valid_ff) begin
            cmd.cmd = CMD_FIN; rsp_st_in = st_ff; valid_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         op_ff <= OP_QUERY;
         st_ff <= ST_OK;
         rsp_st_ff <= ST_OK;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         st_ff <= st_in;
         rsp_st_ff <= rsp_st_in;
         valid_ff <= valid_in;
      end
   end
endmodule

/* hw/rtl/indexed_min_heap_decrease_key_top.sv */
// top level of the indexed min-heap with decrease-key
// depends on imh_pkg, imh_control, imh_datapath and the defines header
// One item is handled at a time. An insert or a decrease-key sifts its entry
// up and an extract sifts the moved last entry down, walking at most 10
// levels. The key/handle memory has a single registered read port. The result
// sits in its own registers, so the next item can be taken in the same cycle
// that a result appears, even while that result is stalled, but a second
// result waits until the first has gone. After reset the position table is
// swept clear, one handle a cycle, before the first item is taken.
`include "indexed_min_heap_decrease_key_top_defines.svh"
module indexed_min_heap_decrease_key_top
   import imh_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_operation,
   input  logic [HANDLE_W-1:0] req_handle,
   input  logic signed [KEY_W-1:0] req_key_value,
   input  logic [DEC_W-1:0]    req_decrement,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [KEY_W-1:0] rsp_min_key,
   output logic [HANDLE_W-1:0] rsp_min_handle,
   output logic                rsp_not_empty,
   output logic [CNT_W-1:0]    rsp_entry_count,
   output logic [2:0]          rsp_status
);
   imh_cmd_type cmd;
   imh_status_type stat;
   logic [KEY_W-1:0] min_key;
   logic [CNT_W-1:0] count;

   // sequencer
   imh_control u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_operation,
      .rsp_valid, .rsp_stall, .rsp_status, .stat, .cmd
   );

   // memories and compare logic
   imh_datapath u_dp (
      .clock, .reset, .cmd, .req_operation, .req_handle,
      .req_key_value(req_key_value), .req_decrement, .stat,
      .min_key, .min_handle(rsp_min_handle), .count
   );

   // result fields all come from registers loaded together
   assign rsp_min_key = min_key;
   assign rsp_entry_count = count;
   assign rsp_not_empty = count != '0;

   // never more entries than capacity
   `IMH_ASSERT_IMPL(a_cnt, clock, reset, 1'b1, count <= CNT_W'(CAPACITY))
   // an empty heap reports a zero minimum
   `IMH_ASSERT_IMPL(a_empty, clock, reset, rsp_valid && !rsp_not_empty, rsp_min_key == '0)
   // a shown item holds while stalled
   `IMH_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
endmodule
